// ===== src/serial_adc_read_sequencer_top_macros.svh =====
// Assertion helpers used by the sequencer top module.
`ifndef SERIAL_ADC_READ_SEQUENCER_TOP_MACROS_SVH
`define SERIAL_ADC_READ_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SARS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, checked outside reset.
`define SARS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

// ===== src/sars_pkg.sv =====
package sars_pkg;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;
    localparam logic [4:0] TOTAL_CYCLES      = 5'd25;
    localparam logic [4:0] FIRST_DATA_CYCLE  = 5'd9;
    localparam logic [4:0] LAST_DATA_CYCLE   = 5'd20;
    localparam int         SAMPLE_W          = 12;

    localparam logic [7:0] CMD_CH0     = 8'h94;
    localparam logic [7:0] CMD_CH1     = 8'hD4;
    localparam logic [7:0] CMD_CH2     = 8'hA4;
    localparam logic [7:0] CMD_CH3     = 8'hE4;
    localparam logic [7:0] CMD_DEFAULT = 8'h90;

    typedef struct packed {
        logic       start_req;
        logic [2:0] channel;
        logic       miso;
    } item_t;

    typedef struct packed {
        logic                sclk;
        logic                mosi;
        logic                cs_n;
        logic                busy_res;
        logic                sample_valid;
        logic [SAMPLE_W-1:0] sample;
    } result_t;

    typedef struct packed {
        logic       active;
        logic [4:0] clock_index;
        logic       clock_level;
    } status_t;

    function automatic logic [7:0] command_for(input logic [2:0] chan);
        logic [7:0] cmd;
        begin
            case (chan)
                3'd0:    cmd = CMD_CH0;
                3'd1:    cmd = CMD_CH1;
                3'd2:    cmd = CMD_CH2;
                3'd3:    cmd = CMD_CH3;
                default: cmd = CMD_DEFAULT;
            endcase
            return cmd;
        end
    endfunction

endpackage

// ===== src/sars_in_stage.sv =====
module sars_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 start_req,
    input  logic [2:0]           channel,
    input  logic                 miso,
    input  logic                 advance,
    output logic                 item_valid,
    output sars_pkg::item_t      item
);

    logic            valid_reg;
    logic            valid_next;
    sars_pkg::item_t item_reg;

    // The stage can refill in the same cycle its beat moves on.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.start_req <= start_req;
            item_reg.channel   <= channel;
            item_reg.miso      <= miso;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/sars_core.sv =====
module sars_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 step_en,
    input  sars_pkg::item_t      item,
    output sars_pkg::result_t    result,
    output sars_pkg::status_t    status
);

    logic [7:0]  half_period_reg;
    logic        active_reg;
    logic        active_next;
    logic [4:0]  clock_index_reg;
    logic [4:0]  clock_index_next;
    logic        clock_level_reg;
    logic        clock_level_next;
    logic [7:0]  tick_count_reg;
    logic [7:0]  tick_count_next;
    logic [7:0]  command_shift_reg;
    logic [7:0]  command_shift_next;
    logic [11:0] sample_shift_reg;
    logic [11:0] sample_shift_next;

    logic [7:0]  half_period;
    logic [8:0]  tick_inc;
    logic [4:0]  index_inc;
    logic        finished;
    logic [11:0] finished_sample;

    always_comb
    begin
        half_period        = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
        tick_inc           = {1'b0, tick_count_reg} + 9'd1;
        index_inc          = clock_index_reg + 5'd1;
        active_next        = active_reg;
        clock_index_next   = clock_index_reg;
        clock_level_next   = clock_level_reg;
        tick_count_next    = tick_count_reg;
        command_shift_next = command_shift_reg;
        sample_shift_next  = sample_shift_reg;
        finished           = 1'b0;
        finished_sample    = 12'd0;

        if (!active_reg)
        begin
            if (item.start_req)
            begin
                active_next        = 1'b1;
                clock_index_next   = 5'd0;
                clock_level_next   = 1'b0;
                tick_count_next    = 8'd0;
                command_shift_next = sars_pkg::command_for(item.channel);
                sample_shift_next  = 12'd0;
            end
        end
        else if (tick_inc >= {1'b0, half_period})
        begin
            tick_count_next = 8'd0;
            if (!clock_level_reg)
            begin
                // Rising edge: data cycles capture this tick's miso level.
                clock_level_next = 1'b1;
                if (clock_index_reg >= sars_pkg::FIRST_DATA_CYCLE &&
                    clock_index_reg <= sars_pkg::LAST_DATA_CYCLE)
                begin
                    sample_shift_next = {sample_shift_reg[10:0], item.miso};
                end
            end
            else
            begin
                clock_level_next   = 1'b0;
                clock_index_next   = index_inc;
                command_shift_next = {command_shift_reg[6:0], 1'b0};
                if (index_inc >= sars_pkg::TOTAL_CYCLES)
                begin
                    finished           = 1'b1;
                    finished_sample    = sample_shift_reg;
                    active_next        = 1'b0;
                    clock_index_next   = 5'd0;
                    command_shift_next = 8'd0;
                end
            end
        end
        else
        begin
            tick_count_next = tick_inc[7:0];
        end

        result.sclk         = active_next & clock_level_next;
        result.mosi         = active_next & command_shift_next[7];
        result.cs_n         = ~active_next;
        result.busy_res     = active_next;
        result.sample_valid = finished;
        result.sample       = finished_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= sars_pkg::HALF_PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            half_period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            clock_index_reg   <= 5'd0;
            clock_level_reg   <= 1'b0;
            tick_count_reg    <= 8'd0;
            command_shift_reg <= 8'd0;
            sample_shift_reg  <= 12'd0;
        end
        else if (step_en)
        begin
            active_reg        <= active_next;
            clock_index_reg   <= clock_index_next;
            clock_level_reg   <= clock_level_next;
            tick_count_reg    <= tick_count_next;
            command_shift_reg <= command_shift_next;
            sample_shift_reg  <= sample_shift_next;
        end
    end

    assign status.active      = active_reg;
    assign status.clock_index = clock_index_reg;
    assign status.clock_level = clock_level_reg;

endmodule

// ===== src/serial_adc_read_sequencer_top.sv =====
// Channel | Handshake            | Beat contents
// in      | in_valid / in_ready   | start_req, channel, miso (one tick)
// out     | out_valid / out_ready | sclk, mosi, cs_n, busy_res, sample_valid, sample
// cfg     | cfg_wr_en             | cfg_wr_data (half period in ticks)
// One beat in and one beat out per clock when both sides keep moving.
// The path has two registers: an input register, then the sequencer step into the output register.
// Reset puts the sequencer idle and the half period at four ticks.
// A stalled output holds its beat; the input register then fills and in_ready drops.
`include "serial_adc_read_sequencer_top_macros.svh"

module serial_adc_read_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_req,
    input  logic [2:0]  channel,
    input  logic        miso,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        sclk,
    output logic        mosi,
    output logic        cs_n,
    output logic        busy_res,
    output logic        sample_valid,
    output logic [11:0] sample
);

    logic                item_valid;
    sars_pkg::item_t     item;
    sars_pkg::result_t   step_result;
    sars_pkg::status_t   status;
    logic                advance;
    logic                out_valid_reg;
    logic                out_valid_next;
    sars_pkg::result_t   result_reg;

    assign advance        = item_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    sars_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_req  (start_req),
        .channel    (channel),
        .miso       (miso),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sars_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .item        (item),
        .result      (step_result),
        .status      (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sclk         = result_reg.sclk;
    assign mosi         = result_reg.mosi;
    assign cs_n         = result_reg.cs_n;
    assign busy_res     = result_reg.busy_res;
    assign sample_valid = result_reg.sample_valid;
    assign sample       = result_reg.sample;

    // A finishing beat always shows the pins back at idle.
    `SARS_ASSERT_NOW(a_finish_idle, clk, rst_n, out_valid && sample_valid,
                     cs_n && !busy_res && !sclk && !mosi)
    // Idle sequencer keeps its clock counters parked.
    `SARS_ASSERT_NOW(a_idle_parked, clk, rst_n, !status.active,
                     status.clock_index == 5'd0 && !status.clock_level)
    // Input backpressure only comes from a stalled, full pipeline.
    `SARS_ASSERT_NOW(a_ready_cause, clk, rst_n, !in_ready,
                     item_valid && out_valid && !out_ready)
    // A step while the sequencer runs always reports busy or a finish.
    `SARS_ASSERT_NEXT(a_step_busy, clk, rst_n, advance && status.active,
                      busy_res || sample_valid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    typedef enum logic [1:0] {MISO_ZEROS, MISO_ONES, MISO_NOISE} miso_mode_t;

    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        start_req = 1'b0;
    logic [2:0]  channel = 3'd0;
    logic        miso = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        sclk;
    logic        mosi;
    logic        cs_n;
    logic        busy_res;
    logic        sample_valid;
    logic [11:0] sample;

    // Shadow copy of the sequencer state, advanced once per accepted input beat.
    logic        seq_active = 1'b0;
    logic [4:0]  seq_cycle = 5'd0;
    logic        seq_level = 1'b0;
    logic [7:0]  seq_ticks = 8'd0;
    logic [7:0]  seq_cmd = 8'd0;
    logic [11:0] seq_data = 12'd0;
    logic [7:0]  half_period = sars_pkg::HALF_PERIOD_RESET;

    sars_pkg::result_t expected_pins[$];
    int      mismatches = 0;
    int      ticks_sent = 0;
    int      quiet_cycles = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;

    serial_adc_read_sequencer_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_req    (start_req),
        .channel      (channel),
        .miso         (miso),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sclk         (sclk),
        .mosi         (mosi),
        .cs_n         (cs_n),
        .busy_res     (busy_res),
        .sample_valid (sample_valid),
        .sample       (sample)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic step_sequencer(input logic go, input logic [2:0] ch, input logic din,
                                  output sars_pkg::result_t pins);
        int unsigned span;
        int unsigned next_tick;
        logic        done;
        span = (half_period == 8'd0) ? 1 : half_period;
        done = 1'b0;
        pins = '0;
        if (!seq_active)
        begin
            if (go)
            begin
                seq_active = 1'b1;
                seq_cycle = 5'd0;
                seq_level = 1'b0;
                seq_ticks = 8'd0;
                seq_data = 12'd0;
                case (ch)
                    3'd0:    seq_cmd = sars_pkg::CMD_CH0;
                    3'd1:    seq_cmd = sars_pkg::CMD_CH1;
                    3'd2:    seq_cmd = sars_pkg::CMD_CH2;
                    3'd3:    seq_cmd = sars_pkg::CMD_CH3;
                    default: seq_cmd = sars_pkg::CMD_DEFAULT;
                endcase
            end
        end
        else
        begin
            next_tick = seq_ticks + 1;
            if (next_tick >= span)
            begin
                seq_ticks = 8'd0;
                if (!seq_level)
                begin
                    // Rising edge: the converter's data pin is captured in the data window.
                    seq_level = 1'b1;
                    if (seq_cycle >= sars_pkg::FIRST_DATA_CYCLE &&
                        seq_cycle <= sars_pkg::LAST_DATA_CYCLE)
                        seq_data = {seq_data[10:0], din};
                end
                else
                begin
                    seq_level = 1'b0;
                    seq_cycle = seq_cycle + 5'd1;
                    seq_cmd = seq_cmd << 1;
                    if (seq_cycle >= sars_pkg::TOTAL_CYCLES)
                    begin
                        done = 1'b1;
                        pins.sample = seq_data;
                        seq_active = 1'b0;
                        seq_cycle = 5'd0;
                        seq_cmd = 8'd0;
                    end
                end
            end
            else
                seq_ticks = next_tick[7:0];
        end
        if (seq_active)
        begin
            pins.sclk = seq_level;
            pins.mosi = seq_cmd[7];
            pins.cs_n = 1'b0;
            pins.busy_res = 1'b1;
        end
        else
            pins.cs_n = 1'b1;
        pins.sample_valid = done;
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Output beats are checked before the new prediction is queued, so a beat that
    // arrives with nothing waiting cannot match its own prediction.
    always @(posedge clk)
    begin : pin_monitor
        sars_pkg::result_t want;
        sars_pkg::result_t next_pins;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pins.size() == 0)
                begin
                    $display("%0t: output beat with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    compare_field("sclk", want.sclk, sclk);
                    compare_field("mosi", want.mosi, mosi);
                    compare_field("cs_n", want.cs_n, cs_n);
                    compare_field("busy_res", want.busy_res, busy_res);
                    compare_field("sample_valid", want.sample_valid, sample_valid);
                    compare_field("sample", want.sample, sample);
                end
            end
            if (in_valid && in_ready)
            begin
                step_sequencer(start_req, channel, miso, next_pins);
                expected_pins.push_back(next_pins);
            end
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_tick(input logic go, input logic [2:0] ch, input logic din);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        start_req <= go;
        channel <= ch;
        miso <= din;
        do
            @(posedge clk);
        while (!in_ready);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_half_period(input logic [7:0] span);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= span;
        @(posedge clk);
        half_period = span;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic miso_level(input miso_mode_t mode);
        case (mode)
            MISO_ZEROS: return 1'b0;
            MISO_ONES:  return 1'b1;
            default:    return 1'($urandom_range(1));
        endcase
    endfunction

    // One start beat, then exactly the 50 half periods of a full transfer. With
    // poke_while_busy the request stays high, including the finishing tick.
    task automatic run_conversion(input logic [2:0] ch, input miso_mode_t mode,
                                  input logic poke_while_busy);
        int span;
        span = 50 * ((half_period == 8'd0) ? 1 : half_period);
        send_tick(1'b1, ch, miso_level(mode));
        repeat (span)
            send_tick(poke_while_busy, 3'($urandom_range(7)), miso_level(mode));
    endtask

    task automatic test_idle_pins();
        repeat (6)
            send_tick(1'b0, 3'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    // The first serial clock cycle runs at the reset half period; the rest of the
    // transfer then runs at one tick per level.
    task automatic test_reset_half_period();
        send_tick(1'b1, 3'd2, 1'($urandom_range(1)));
        repeat (10)
            send_tick(1'b0, 3'($urandom_range(7)), 1'($urandom_range(1)));
        set_half_period(8'd1);
        repeat (52)
            send_tick(1'b0, 3'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    task automatic test_channel_commands();
        int ch;
        set_half_period(8'd1);
        for (ch = 0; ch < 8; ch++)
        begin
            run_conversion(ch[2:0], (ch == 0) ? MISO_ONES : (ch == 1) ? MISO_ZEROS : MISO_NOISE,
                           ch[0]);
            send_tick(1'b0, 3'd7, 1'b1);
        end
    endtask

    // The longest half period is held through the first rising edge, then the
    // transfer is finished at one tick per level.
    task automatic test_half_period_extremes();
        set_half_period(8'd0);
        run_conversion(3'd3, MISO_NOISE, 1'b1);
        set_half_period(8'd255);
        send_tick(1'b1, 3'd7, 1'b1);
        repeat (260)
            send_tick(1'b1, 3'($urandom_range(7)), 1'b1);
        set_half_period(8'd1);
        repeat (52)
            send_tick(1'b0, 3'd5, 1'($urandom_range(1)));
    endtask

    task automatic test_random_traffic();
        int phase;
        int goal;
        int pick;
        logic [7:0] span;
        for (phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 81 : 0;
            receiver_stall_pct = (phase == 0) ? 81 : (phase == 1) ? 10 : 0;
            goal = ticks_sent + 60;
            while (ticks_sent < goal)
            begin
                pick = $urandom_range(99);
                span = (pick < 50) ? 8'd1 : (pick < 75) ? 8'd2 : (pick < 90) ? 8'd3 :
                       8'($urandom_range(6));
                set_half_period(span);
                if ($urandom_range(99) < 85)
                    run_conversion(3'($urandom_range(7)), MISO_NOISE, 1'($urandom_range(1)));
                else
                    repeat ($urandom_range(1, 10))
                        send_tick(1'($urandom_range(1)), 3'($urandom_range(7)),
                                  1'($urandom_range(1)));
                repeat ($urandom_range(3))
                    send_tick(1'b0, 3'($urandom_range(7)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_pins();
        test_reset_half_period();
        test_channel_commands();
        test_half_period_extremes();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/sars_pkg.sv
src/sars_in_stage.sv
src/sars_core.sv
src/serial_adc_read_sequencer_top.sv
tb/testbench.sv
